// ----- src/image_2d_convolution_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D convolution unit
// ----------------------------------------------------------------------------
`ifndef IMAGE_2D_CONVOLUTION_UNIT_DEFINES_SVH
`define IMAGE_2D_CONVOLUTION_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define I2DC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define I2DC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/i2dc_pkg.sv -----
// ----------------------------------------------------------------------------
// i2dc_pkg
// Types and fixed constants of the 2-D convolution unit.
// ----------------------------------------------------------------------------
package i2dc_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 8;
    localparam int PIXEL_W    = 8;
    localparam int COEFF_W    = 16;
    localparam int RESULT_W   = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int IMG_SIZE_W = 9;
    localparam int MSK_SIZE_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WR_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_COEFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_SIZE  = 1'd1;

    localparam logic [IMG_SIZE_W-1:0] IMAGE_SIZE_RST = 9'd256;
    localparam logic [MSK_SIZE_W-1:0] MASK_SIZE_RST  = 3'd3;

    localparam int RESULT_MAX = 8388607;
    localparam int RESULT_MIN = -8388608;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic [PIXEL_W-1:0]        pixel;
        logic signed [COEFF_W-1:0] coeff;
    } t_cmd_in;

    typedef struct packed {
        logic signed [RESULT_W-1:0] conv_value;
        logic                       saturated;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_DIV,
        S_SAT
    } t_state;

endpackage

// ----- src/image_2d_convolution_unit.sv -----
// ----------------------------------------------------------------------------
// image_2d_convolution_unit
// Zero-padded 2-D convolution of a square 8-bit image with an odd square
// mask of signed fixed-point coefficients, one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
// Channel     Direction  Handshake               Payload
// command     in         start high, busy low    i_cmd (t_cmd_in)
// result      out        o_valid, one cycle      o_result (t_result)
// config      in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// A compute command steps through every tap of the mask in use, one tap per
// cycle through the shared multiplier, then takes flush, truncation and
// saturation steps before the result strobe.
// Writes and unknown commands skip to saturation and show a zero result.
// A new command is taken in the cycle the result strobe is shown.
// Reset is synchronous, active low; the receiver cannot stall.
// ----------------------------------------------------------------------------
module image_2d_convolution_unit #(
    parameter int MAX_IMAGE_SIDE  = 256,
    parameter int MAX_MASK_SIDE   = 7,
    parameter int COEFF_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  i2dc_pkg::t_cmd_in                   i_cmd,
    output logic                                o_valid,
    output i2dc_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [i2dc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [i2dc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IMG_N_W   = $clog2(MAX_IMAGE_SIDE + 1);
    localparam int CW        = ((IMG_N_W > i2dc_pkg::COORD_W + 1) ? IMG_N_W
                                : i2dc_pkg::COORD_W + 1) + 1;
    localparam int PIX_AW    = $clog2(MAX_IMAGE_SIDE);
    localparam int IMG_DEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int MSK_DEPTH = MAX_MASK_SIDE * MAX_MASK_SIDE;
    localparam int MSK_AW    = (MSK_DEPTH > 1) ? $clog2(MSK_DEPTH) : 1;
    localparam int TAP_W     = $clog2(MAX_MASK_SIDE + 1);
    localparam int PROD_W    = i2dc_pkg::PIXEL_W + 1 + i2dc_pkg::COEFF_W;
    localparam int ACC_W     = PROD_W + $clog2(MSK_DEPTH + 1);
    localparam int RW        = i2dc_pkg::RESULT_W;

    localparam logic [CW-1:0]            MAX_IMG_CW = CW'(MAX_IMAGE_SIDE);
    localparam logic [3:0]               MAX_MSK_4  = 4'(MAX_MASK_SIDE);
    localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'((1 << COEFF_FRAC_BITS) - 1);
    localparam logic signed [ACC_W-1:0]  RES_MAX_A  = ACC_W'(i2dc_pkg::RESULT_MAX);
    localparam logic signed [ACC_W-1:0]  RES_MIN_A  = ACC_W'(i2dc_pkg::RESULT_MIN);
    localparam logic signed [RW-1:0]     RES_MAX_R  = RW'(i2dc_pkg::RESULT_MAX);
    localparam logic signed [RW-1:0]     RES_MIN_R  = RW'(i2dc_pkg::RESULT_MIN);

    i2dc_pkg::t_state r_state, n_state;

    logic [i2dc_pkg::IMG_SIZE_W-1:0] r_image_size;
    logic [i2dc_pkg::MSK_SIZE_W-1:0] r_mask_size;

    logic [i2dc_pkg::PIXEL_W-1:0]        r_image_store [IMG_DEPTH];
    logic signed [i2dc_pkg::COEFF_W-1:0] r_mask_store  [MSK_DEPTH];

    logic [CW-1:0]                  r_n;
    logic [TAP_W-1:0]               r_m, r_half;
    logic [i2dc_pkg::COORD_W-1:0]   r_row, r_col;
    logic [TAP_W-1:0]               r_a, r_b, n_a, n_b;
    logic                           r_flush, n_flush;
    logic                           r_v1, r_v2;
    logic [i2dc_pkg::PIXEL_W-1:0]   r_img_q;
    logic signed [i2dc_pkg::COEFF_W-1:0] r_msk_q;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc, r_quot, acc_biased;
    logic                           r_valid;
    i2dc_pkg::t_result              r_out;

    logic             accept, is_compute;
    logic [CW-1:0]    img_ext, n_eff;
    logic [3:0]       msk_ext, m_eff4;
    logic [TAP_W-1:0] m_eff, tap_last;
    logic             last_tap, issue, tap_ok;
    logic [CW-1:0]    tap_r, tap_c;
    logic [IMG_AW-1:0] rd_img_addr, wr_img_addr;
    logic [MSK_AW-1:0] rd_msk_addr, wr_msk_addr;
    logic             img_we, msk_we;
    logic [CW-1:0]    wr_row_ext, wr_col_ext;
    logic             sat_hi, sat_lo;

    assign busy       = (r_state != i2dc_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign is_compute = (i_cmd.command == i2dc_pkg::CMD_COMPUTE);

    // clamp the sizes in use to the store bounds
    assign img_ext = CW'(r_image_size);
    assign n_eff   = (img_ext == '0) ? CW'(1)
                   : ((img_ext > MAX_IMG_CW) ? MAX_IMG_CW : img_ext);
    assign msk_ext = 4'(r_mask_size);
    assign m_eff4  = (msk_ext > MAX_MSK_4) ? MAX_MSK_4 : msk_ext;
    assign m_eff   = TAP_W'(m_eff4);

    // store writes
    assign wr_row_ext  = CW'(i_cmd.row);
    assign wr_col_ext  = CW'(i_cmd.col);
    assign img_we      = accept && (i_cmd.command == i2dc_pkg::CMD_WR_PIXEL)
                         && (wr_row_ext < MAX_IMG_CW) && (wr_col_ext < MAX_IMG_CW);
    assign wr_img_addr = IMG_AW'(wr_row_ext[PIX_AW-1:0]) * IMG_AW'(MAX_IMAGE_SIDE)
                       + IMG_AW'(wr_col_ext[PIX_AW-1:0]);
    assign msk_we      = accept && (i_cmd.command == i2dc_pkg::CMD_WR_COEFF)
                         && (i_cmd.row < i2dc_pkg::COORD_W'(MAX_MASK_SIDE))
                         && (i_cmd.col < i2dc_pkg::COORD_W'(MAX_MASK_SIDE));
    assign wr_msk_addr = MSK_AW'(i_cmd.row) * MSK_AW'(MAX_MASK_SIDE) + MSK_AW'(i_cmd.col);

    // current tap position in the image; negative values have the top bit set
    assign tap_r  = CW'(r_row) - CW'(r_half) + CW'(r_a);
    assign tap_c  = CW'(r_col) - CW'(r_half) + CW'(r_b);
    assign tap_ok = !tap_r[CW-1] && !tap_c[CW-1] && (tap_r < r_n) && (tap_c < r_n);

    assign rd_img_addr = tap_ok ? (IMG_AW'(tap_r[PIX_AW-1:0]) * IMG_AW'(MAX_IMAGE_SIDE)
                                   + IMG_AW'(tap_c[PIX_AW-1:0])) : '0;
    assign rd_msk_addr = MSK_AW'(r_a) * MSK_AW'(MAX_MASK_SIDE) + MSK_AW'(r_b);

    assign tap_last = r_m - TAP_W'(1);
    assign last_tap = (r_a == tap_last) && (r_b == tap_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2dc_pkg::S_IDLE: begin
                if (accept) begin
                    if (is_compute) begin
                        n_state = (m_eff == '0) ? i2dc_pkg::S_FLUSH : i2dc_pkg::S_RUN;
                    end else begin
                        n_state = i2dc_pkg::S_SAT;
                    end
                end
            end
            i2dc_pkg::S_RUN: begin
                if (last_tap) begin
                    n_state = i2dc_pkg::S_FLUSH;
                end
            end
            i2dc_pkg::S_FLUSH: begin
                if (r_flush) begin
                    n_state = i2dc_pkg::S_DIV;
                end
            end
            i2dc_pkg::S_DIV:  n_state = i2dc_pkg::S_SAT;
            i2dc_pkg::S_SAT:  n_state = i2dc_pkg::S_IDLE;
            default:          n_state = i2dc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: tap counters and flush step
    always_comb begin
        issue   = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_flush = r_flush;
        case (r_state)
            i2dc_pkg::S_IDLE: begin
                n_a     = '0;
                n_b     = '0;
                n_flush = 1'b0;
            end
            i2dc_pkg::S_RUN: begin
                issue = 1'b1;
                if (r_b == tap_last) begin
                    n_b = '0;
                    n_a = r_a + TAP_W'(1);
                end else begin
                    n_b = r_b + TAP_W'(1);
                end
            end
            i2dc_pkg::S_FLUSH: n_flush = 1'b1;
            default: ;
        endcase
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign acc_biased = r_acc[ACC_W-1] ? (r_acc + ROUND_BIAS) : r_acc;
    assign sat_hi     = (r_quot > RES_MAX_A);
    assign sat_lo     = (r_quot < RES_MIN_A);

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_image_store[wr_img_addr] <= i_cmd.pixel;
        end
        r_img_q <= r_image_store[rd_img_addr];
    end

    always_ff @(posedge i_clk) begin
        if (msk_we) begin
            r_mask_store[wr_msk_addr] <= i_cmd.coeff;
        end
        r_msk_q <= r_mask_store[rd_msk_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= i2dc_pkg::S_IDLE;
            r_image_size <= i2dc_pkg::IMAGE_SIZE_RST;
            r_mask_size  <= i2dc_pkg::MASK_SIZE_RST;
            r_a          <= '0;
            r_b          <= '0;
            r_flush      <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_flush <= n_flush;
            r_v1    <= issue && tap_ok;
            r_v2    <= r_v1;
            r_valid <= (r_state == i2dc_pkg::S_SAT);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    i2dc_pkg::CFG_IMAGE_SIZE: r_image_size <= i_cfg_data[i2dc_pkg::IMG_SIZE_W-1:0];
                    i2dc_pkg::CFG_MASK_SIZE:  r_mask_size  <= i_cfg_data[i2dc_pkg::MSK_SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath: latch the command, multiply, accumulate, truncate, saturate
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= n_eff;
            r_m    <= m_eff;
            r_half <= m_eff >> 1;
            r_row  <= i_cmd.row;
            r_col  <= i_cmd.col;
        end
        r_prod <= $signed({1'b0, r_img_q}) * r_msk_q;
        if (accept) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (accept) begin
            r_quot <= '0;
        end else if (r_state == i2dc_pkg::S_DIV) begin
            r_quot <= acc_biased >>> COEFF_FRAC_BITS;
        end
        if (r_state == i2dc_pkg::S_SAT) begin
            r_out.conv_value <= sat_hi ? RES_MAX_R : (sat_lo ? RES_MIN_R : r_quot[RW-1:0]);
            r_out.saturated  <= sat_hi || sat_lo;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ----- src/i2dc_checker.sv -----
// ----------------------------------------------------------------------------
// i2dc_checker
// Port-level checks of the 2-D convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_2d_convolution_unit_defines.svh"

module i2dc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input i2dc_pkg::t_result o_result
);

    // a taken transaction holds the unit busy in the next cycle
    `I2DC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")

    // the result strobe is shown only once the unit is free again
    `I2DC_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")

    // each command ends with its result
    `I2DC_ASSERT_IMP(a_done_valid, i_clk, i_rst_n, $fell(busy), o_valid, "busy dropped without result")

    `I2DC_ASSERT_NEXT(a_valid_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than a cycle")

    // a clipped result sits on one of the range limits
    `I2DC_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, o_valid && o_result.saturated, (o_result.conv_value == 24'sh7FFFFF) || (o_result.conv_value == 24'sh800000), "saturated result off the limits")

endmodule

bind image_2d_convolution_unit i2dc_checker u_i2dc_checker (.*);

// ----- test/image_2d_convolution_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_2d_convolution_unit_tb
// Self-checking bench for the 2-D convolution unit. A cycle-free predictor
// keeps its own image and mask stores and works out the result of every
// accepted command. A directed part covers field extremes, unknown commands,
// ignored mask writes and register corners. It is followed by random phases
// under changing image and mask sizes.
// ----------------------------------------------------------------------------
module image_2d_convolution_unit_tb;

    localparam int IMAGE_SIDE_MAX = 256;
    localparam int MASK_SIDE_MAX  = 7;
    localparam int FRAC_BITS      = 8;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int TAIL_CYCLES    = 64;
    localparam int CYCLE_LIMIT    = 1000000;

    localparam logic [i2dc_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    i2dc_pkg::t_cmd_in               i_cmd;
    logic                            o_valid;
    i2dc_pkg::t_result               o_result;
    logic                            i_cfg_we;
    logic [i2dc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [i2dc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    logic [i2dc_pkg::PIXEL_W-1:0]        pixels        [0:IMAGE_SIDE_MAX*IMAGE_SIDE_MAX-1];
    bit                                  pixel_written [0:IMAGE_SIDE_MAX*IMAGE_SIDE_MAX-1];
    logic signed [i2dc_pkg::COEFF_W-1:0] mask_taps     [0:MASK_SIDE_MAX*MASK_SIDE_MAX-1];
    bit                                  tap_written   [0:MASK_SIDE_MAX*MASK_SIDE_MAX-1];
    logic [i2dc_pkg::IMG_SIZE_W-1:0]     image_size_reg;
    logic [i2dc_pkg::MSK_SIZE_W-1:0]     mask_size_reg;

    i2dc_pkg::t_result expected_results [$];
    int      items_sent;
    int      computes_sent;
    int      results_checked;
    int      mismatches;
    int      settings_used;
    bit      steady;

    image_2d_convolution_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    function automatic int image_side();
        int n;
        n = int'(image_size_reg);
        if (n < 1) n = 1;
        if (n > IMAGE_SIDE_MAX) n = IMAGE_SIDE_MAX;
        return n;
    endfunction

    function automatic int mask_side();
        int m;
        m = int'(mask_size_reg);
        if (m > MASK_SIDE_MAX) m = MASK_SIDE_MAX;
        return m;
    endfunction

    // exact sum of products around (row, col); out-of-image neighbours are zero
    function automatic longint window_sum(int row, int col);
        int     n;
        int     m;
        int     half;
        int     r;
        int     c;
        longint acc;
        n    = image_side();
        m    = mask_side();
        half = m / 2;
        acc  = 0;
        for (int a = 0; a < m; a++) begin
            r = row - half + a;
            if (r < 0 || r >= n) continue;
            for (int b = 0; b < m; b++) begin
                c = col - half + b;
                if (c < 0 || c >= n) continue;
                acc += longint'(pixels[r*IMAGE_SIDE_MAX + c]) *
                       longint'(mask_taps[a*MASK_SIDE_MAX + b]);
            end
        end
        return acc;
    endfunction

    function automatic i2dc_pkg::t_result execute_command(i2dc_pkg::t_cmd_in c);
        i2dc_pkg::t_result res;
        longint  q;
        int      idx;
        res = '0;
        case (c.command)
            i2dc_pkg::CMD_WR_PIXEL: begin
                idx = int'(c.row) * IMAGE_SIDE_MAX + int'(c.col);
                pixels[idx]        = c.pixel;
                pixel_written[idx] = 1'b1;
            end
            i2dc_pkg::CMD_WR_COEFF: begin
                // coordinates beyond the mask store are dropped
                if (c.row < MASK_SIDE_MAX && c.col < MASK_SIDE_MAX) begin
                    idx = int'(c.row) * MASK_SIDE_MAX + int'(c.col);
                    mask_taps[idx]   = c.coeff;
                    tap_written[idx] = 1'b1;
                end
            end
            i2dc_pkg::CMD_COMPUTE: begin
                // signed division truncates toward zero
                q = window_sum(int'(c.row), int'(c.col)) / (longint'(1) << FRAC_BITS);
                if (q > i2dc_pkg::RESULT_MAX) begin
                    q = i2dc_pkg::RESULT_MAX;
                    res.saturated = 1'b1;
                end
                if (q < i2dc_pkg::RESULT_MIN) begin
                    q = i2dc_pkg::RESULT_MIN;
                    res.saturated = 1'b1;
                end
                res.conv_value = q[i2dc_pkg::RESULT_W-1:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic i2dc_pkg::t_cmd_in make_cmd(logic [i2dc_pkg::CMD_W-1:0] cmd,
                                                   int row, int col,
                                                   logic [i2dc_pkg::PIXEL_W-1:0] pixel,
                                                   logic [i2dc_pkg::COEFF_W-1:0] coeff);
        i2dc_pkg::t_cmd_in c;
        c.command = cmd;
        c.row     = row[i2dc_pkg::COORD_W-1:0];
        c.col     = col[i2dc_pkg::COORD_W-1:0];
        c.pixel   = pixel;
        c.coeff   = coeff;
        return c;
    endfunction

    function automatic logic [i2dc_pkg::PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return i2dc_pkg::PIXEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [i2dc_pkg::COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return i2dc_pkg::COEFF_W'($urandom);
        endcase
    endfunction

    // mostly inside the image or just past its edge, now and then anywhere
    function automatic int pick_coord(int n);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, (n < 255) ? n : 255);
    endfunction

    // start stays high across back-to-back transactions; lowered only for a gap
    task automatic send_cmd(input i2dc_pkg::t_cmd_in c);
        int gap;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(execute_command(c));
        items_sent++;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            // half the time let the block finish first, so gaps also land while idle
            if ($urandom_range(0, 1)) begin
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // with nothing outstanding start is already low
    task automatic drain_results();
        if (expected_results.size() != 0) begin
            start <= 1'b0;
            while (expected_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // call only with nothing outstanding
    task automatic configure(input logic [i2dc_pkg::CFG_DATA_W-1:0] img,
                             input logic [i2dc_pkg::CFG_DATA_W-1:0] msk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= i2dc_pkg::CFG_IMAGE_SIZE;
        i_cfg_data <= img;
        @(posedge i_clk);
        image_size_reg = img[i2dc_pkg::IMG_SIZE_W-1:0];
        i_cfg_idx  <= i2dc_pkg::CFG_MASK_SIZE;
        i_cfg_data <= msk;
        @(posedge i_clk);
        mask_size_reg = msk[i2dc_pkg::MSK_SIZE_W-1:0];
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // fill any unwritten tap or in-image neighbour, then compute
    task automatic convolve_at(input int row, input int col);
        int n;
        int m;
        int half;
        int r;
        int c;
        n    = image_side();
        m    = mask_side();
        half = m / 2;
        for (int a = 0; a < m; a++)
            for (int b = 0; b < m; b++)
                if (!tap_written[a*MASK_SIDE_MAX + b])
                    send_cmd(make_cmd(i2dc_pkg::CMD_WR_COEFF, a, b, pick_pixel(),
                                      pick_coeff()));
        for (int a = 0; a < m; a++) begin
            r = row - half + a;
            if (r < 0 || r >= n) continue;
            for (int b = 0; b < m; b++) begin
                c = col - half + b;
                if (c < 0 || c >= n) continue;
                if (!pixel_written[r*IMAGE_SIDE_MAX + c])
                    send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, r, c, pick_pixel(),
                                      i2dc_pkg::COEFF_W'($urandom)));
            end
        end
        send_cmd(make_cmd(i2dc_pkg::CMD_COMPUTE, row, col, i2dc_pkg::PIXEL_W'($urandom),
                          i2dc_pkg::COEFF_W'($urandom)));
        computes_sent++;
    endtask

    always @(posedge i_clk) begin : check_results
        i2dc_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: conv_value %0d saturated %0b",
                       o_result.conv_value, o_result.saturated);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_result.conv_value !== want.conv_value) begin
                    $error("conv_value: expected %0d, got %0d",
                           want.conv_value, o_result.conv_value);
                    mismatches++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, o_result.saturated);
                    mismatches++;
                end
            end
        end
    end

    // reset register values, coefficient and pixel extremes, ignored writes
    task automatic test_reset_defaults();
        logic [i2dc_pkg::COEFF_W-1:0] k;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++) begin
                k = i2dc_pkg::COEFF_W'($urandom);
                if (a == 0 && b == 0) k = 16'h8000;
                if (a == 2 && b == 2) k = 16'h7fff;
                send_cmd(make_cmd(i2dc_pkg::CMD_WR_COEFF, a, b,
                                  i2dc_pkg::PIXEL_W'($urandom), k));
            end
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, 0, 0, 8'd255, i2dc_pkg::COEFF_W'($urandom)));
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, 0, 1, 8'd0, i2dc_pkg::COEFF_W'($urandom)));
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, 1, 0, 8'd255, i2dc_pkg::COEFF_W'($urandom)));
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, 1, 1, 8'd128, i2dc_pkg::COEFF_W'($urandom)));
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, 255, 255, 8'd255, 16'hffff));
        convolve_at(0, 0);
        send_cmd(make_cmd(CMD_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 255),
                          i2dc_pkg::PIXEL_W'($urandom), i2dc_pkg::COEFF_W'($urandom)));
        // mask coordinates past the store must leave it untouched
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_COEFF, 7, 255, 8'd0, 16'h7fff));
        send_cmd(make_cmd(i2dc_pkg::CMD_WR_COEFF, 1, 7, 8'd0, 16'h8000));
        convolve_at(1, 1);
    endtask

    // image size 0 and above the maximum, mask size 0 and even
    task automatic test_register_corners();
        drain_results();
        configure(9'd0, 9'd3);
        convolve_at(0, 0);
        convolve_at(255, 255);
        drain_results();
        configure(9'd511, 9'd0);
        convolve_at(1, 1);
        drain_results();
        configure(9'd511, 9'd2);
        convolve_at(1, 1);
    endtask

    task automatic test_random_traffic();
        int                              base;
        int                              n;
        int                              pick;
        logic [i2dc_pkg::CFG_DATA_W-1:0] img;
        logic [i2dc_pkg::MSK_SIZE_W-1:0] msk;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       img = 9'd0;
                1:       img = 9'd1;
                2:       img = 9'd256;
                3:       img = i2dc_pkg::CFG_DATA_W'($urandom_range(257, 511));
                4:       img = i2dc_pkg::CFG_DATA_W'($urandom_range(2, 255));
                default: img = i2dc_pkg::CFG_DATA_W'($urandom_range(2, 12));
            endcase
            pick = $urandom_range(0, 9);
            msk  = (pick > 7) ? 3'd7 : i2dc_pkg::MSK_SIZE_W'(pick);
            configure(img, {6'($urandom), msk});
            steady = ($urandom_range(0, 3) == 0);
            n = image_side();
            repeat ($urandom_range(20, 120)) begin
                // stop the phase once the item budget is spent
                if (items_sent - base >= RANDOM_ITEMS) break;
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    drain_results();
                else if (pick < 72)
                    convolve_at(pick_coord(n), pick_coord(n));
                else if (pick < 84)
                    send_cmd(make_cmd(i2dc_pkg::CMD_WR_PIXEL, pick_coord(n), pick_coord(n),
                                      pick_pixel(), i2dc_pkg::COEFF_W'($urandom)));
                else if (pick < 94)
                    send_cmd(make_cmd(i2dc_pkg::CMD_WR_COEFF,
                                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 6),
                                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                                  : $urandom_range(0, 6),
                                      i2dc_pkg::PIXEL_W'($urandom), pick_coeff()));
                else
                    send_cmd(make_cmd(CMD_UNKNOWN, $urandom_range(0, 255),
                                      $urandom_range(0, 255), i2dc_pkg::PIXEL_W'($urandom),
                                      i2dc_pkg::COEFF_W'($urandom)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= i2dc_pkg::CFG_IMAGE_SIZE;
        i_cfg_data <= '0;
        image_size_reg  = i2dc_pkg::IMAGE_SIZE_RST;
        mask_size_reg   = i2dc_pkg::MASK_SIZE_RST;
        items_sent      = 0;
        computes_sent   = 0;
        results_checked = 0;
        mismatches      = 0;
        settings_used   = 1;
        steady          = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_corners();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("tb: %0d commands sent (%0d computes), %0d results checked",
                 items_sent, computes_sent, results_checked);
        $display("tb: %0d image/mask size settings used, %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
